// ----- hdl/hng_pkg.sv -----
// ----------------------------------------------------------------------------
// hng_pkg
// Shared types, widths and helpers of the heightmap normal generator.
// ----------------------------------------------------------------------------
package hng_pkg;

  localparam int unsigned HW     = 16;  // height sample
  localparam int unsigned GSW    = 11;  // grid_side register
  localparam int unsigned CDW    = 16;  // cell_double register
  localparam int unsigned POSW   = 10;  // pos_x / pos_z fields
  localparam int unsigned DW     = 17;  // signed height difference
  localparam int unsigned PRW    = 33;  // one square
  localparam int unsigned SQW    = 34;  // sum of three squares
  localparam int unsigned LW     = 17;  // vector length
  localparam int unsigned NXW    = 16;  // normal_x / normal_z
  localparam int unsigned NYW    = 15;  // normal_y
  localparam int unsigned OTDW   = 104; // output tdata, byte padded

  typedef enum logic {
    REG_GRID_SIDE   = 1'b0,
    REG_CELL_DOUBLE = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PICK,
    ST_READ,
    ST_MUL,
    ST_NORM,
    ST_OUT
  } seq_state_e;

  typedef enum logic [1:0] {
    NS_IDLE,
    NS_SQRT,
    NS_DIV,
    NS_DONE
  } norm_state_e;

  typedef struct packed {
    logic [SQW-1:0]        sq;
    logic signed [DW-1:0]  dx;
    logic [CDW-1:0]        dy;
    logic signed [DW-1:0]  dz;
  } norm_req_t;

  typedef struct packed {
    logic signed [NXW-1:0] nx;
    logic [NYW-1:0]        ny;
    logic signed [NXW-1:0] nz;
  } norm_res_t;

  // row slot arithmetic modulo 3
  function automatic logic [1:0] inc3(input logic [1:0] m);
    return (m == 2'd2) ? 2'd0 : m + 2'd1;
  endfunction

  function automatic logic [1:0] dec3(input logic [1:0] m);
    return (m == 2'd0) ? 2'd2 : m - 2'd1;
  endfunction

endpackage

// ----- hdl/hng_ram.sv -----
// ----------------------------------------------------------------------------
// hng_ram
// Row store: simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hng_ram #(
  parameter int unsigned DEPTH = 3072,
  parameter int unsigned AW    = 12,
  parameter int unsigned WW    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [WW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [WW-1:0] rdata_o
);

  logic [WW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- hdl/hng_norm.sv -----
// ----------------------------------------------------------------------------
// hng_norm
// Normaliser: bit-serial integer square root, then three restoring divides.
// ----------------------------------------------------------------------------
module hng_norm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  hng_pkg::norm_req_t req_i,
  output logic               done_o,
  output hng_pkg::norm_res_t res_o
);
  import hng_pkg::*;

  localparam int unsigned VW = SQW + 1;

  norm_state_e state_q, state_d;
  norm_req_t   req_q;
  logic [VW-1:0] v_q, root_q, bit_q;
  logic [4:0]    step_q;
  logic [1:0]    comp_q;
  logic [LW-1:0] len_q;
  logic [LW:0]   rem_q;
  logic [15:0]   quo_q;
  norm_res_t     res_q;

  logic [VW-1:0] trial_sum;
  logic          sq_ge;
  logic [LW-1:0] mag;
  logic          neg;
  logic [LW+1:0] trial;
  logic          dv_ge;
  logic [15:0]   quo_n;
  logic [NYW-1:0] qc;

  assign trial_sum = root_q + bit_q;
  assign sq_ge     = (v_q >= trial_sum);

  always_comb begin
    unique case (comp_q)
      2'd0:    begin mag = req_q.dx[DW-1] ? LW'(-req_q.dx) : LW'(req_q.dx); neg = req_q.dx[DW-1]; end
      2'd1:    begin mag = LW'(req_q.dy); neg = 1'b0; end
      default: begin mag = req_q.dz[DW-1] ? LW'(-req_q.dz) : LW'(req_q.dz); neg = req_q.dz[DW-1]; end
    endcase
  end

  // first step compares the magnitude itself, later steps the shifted remainder
  assign trial = (step_q == 5'd0) ? (LW+2)'(mag) : {rem_q, 1'b0};
  assign dv_ge = (trial >= (LW+2)'(len_q));
  assign quo_n = {quo_q[14:0], dv_ge};
  assign qc    = (quo_n > 16'd32767) ? NYW'(32767) : quo_n[NYW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      NS_IDLE: if (start_i) state_d = NS_SQRT;
      NS_SQRT: if (step_q == 5'd16) state_d = NS_DIV;
      NS_DIV:  if (step_q == 5'd15 && comp_q == 2'd2) state_d = NS_DONE;
      default: state_d = NS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= NS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      NS_IDLE: begin
        req_q  <= req_i;
        v_q    <= VW'(req_i.sq);
        root_q <= '0;
        bit_q  <= VW'(1) << (SQW - 2);
        step_q <= '0;
        comp_q <= '0;
      end
      NS_SQRT: begin
        if (sq_ge) begin
          v_q    <= v_q - trial_sum;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (step_q == 5'd16) begin
          step_q <= '0;
          rem_q  <= '0;
          quo_q  <= '0;
          len_q  <= sq_ge ? LW'((root_q >> 1) + bit_q) : LW'(root_q >> 1);
        end else begin
          step_q <= step_q + 5'd1;
        end
      end
      NS_DIV: begin
        if (step_q == 5'd15) begin
          step_q <= '0;
          rem_q  <= '0;
          quo_q  <= '0;
          comp_q <= comp_q + 2'd1;
          unique case (comp_q)
            2'd0:    res_q.nx <= (len_q == '0) ? '0 : (neg ? -NXW'(qc) : NXW'(qc));
            2'd1:    res_q.ny <= (len_q == '0) ? '0 : qc;
            default: res_q.nz <= (len_q == '0) ? '0 : (neg ? -NXW'(qc) : NXW'(qc));
          endcase
        end else begin
          step_q <= step_q + 5'd1;
          rem_q  <= dv_ge ? (LW+1)'(trial - (LW+2)'(len_q)) : (LW+1)'(trial);
          quo_q  <= quo_n;
        end
      end
      default: ;
    endcase
  end

  assign done_o = (state_q == NS_DONE);
  assign res_o  = res_q;

endmodule

// ----- hdl/heightmap_normal_generator_unit.sv -----
// ----------------------------------------------------------------------------
// heightmap_normal_generator_unit
// Streaming central-difference normal generator over a square heightmap.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | payload
//  s_axis   | in  | tvalid/tready        | tdata[15:0] height
//  m_axis   | out | tvalid/tready, tlast | tdata: pos, normal, min/max, map_done
//  cfg      | in  | cfg_we_i             | cfg_idx_i, cfg_data_i
//
//  A sample that gives no normal leaves the sequencer in ST_IDLE. Each normal
//  passes through a pick, the row store reads (single read port), the shared
//  squarer, the square root steps, three divides and a done state in hng_norm,
//  and an output load. A last-row sample may give up to three normals.
//  Reset clears counters and running min/max, sets registers to defaults;
//  the row store is not cleared. A stalled m_axis holds the sequencer in ST_OUT;
//  no new sample is taken until every normal of the current one has been loaded.
// ----------------------------------------------------------------------------
module heightmap_normal_generator_unit #(
  parameter int unsigned MAX_SIDE = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // height
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [15:0]               s_axis_tdata,
  // pos_x, pos_z, normal_x, normal_y, normal_z, min_height, max_height, map_done
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [hng_pkg::OTDW-1:0]  m_axis_tdata,
  output logic                      m_axis_tlast,
  // configuration writes
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [15:0]               cfg_data_i
);
  import hng_pkg::*;

  localparam int unsigned SW    = $clog2(MAX_SIDE + 1);
  localparam int unsigned EW    = (SW > GSW) ? SW : GSW;
  localparam int unsigned DEPTH = 3 * MAX_SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);

  // registers
  logic [GSW-1:0] grid_q;
  logic [CDW-1:0] cell_q;

  // position and running statistics
  logic [SW-1:0] col_q, row_q;
  logic [1:0]    zm_q;
  logic [HW-1:0] min_q, max_q;

  // current sample and pending normals
  seq_state_e    state_q, state_d;
  logic [SW-1:0] cx_q, cz_q;
  logic [1:0]    cm_q;
  logic [2:0]    pend_q;
  logic [SW-1:0] px_q, pz_q;
  logic [1:0]    pm_q;
  logic          last_q;

  logic [2:0]    rcnt_q;
  logic [HW-1:0] nbr_q [4];
  logic [2:0]    mcnt_q;
  logic [PRW-1:0] prod_q;
  logic [SQW-1:0] acc_q;

  logic [OTDW-1:0] tdata_q;
  logic            tvalid_q, tlast_q;

  // effective side
  logic [EW-1:0] gs_ext;
  logic [SW-1:0] side;
  assign gs_ext = EW'(grid_q);
  always_comb begin
    priority if (gs_ext < EW'(2))             side = SW'(2);
    else if (gs_ext > EW'(MAX_SIDE))          side = SW'(MAX_SIDE);
    else                                      side = SW'(gs_ext);
  end

  function automatic logic [AW-1:0] slot_addr(input logic [1:0] m, input logic [SW-1:0] x);
    logic [AW-1:0] base;
    unique case (m)
      2'd0:    base = '0;
      2'd1:    base = AW'(MAX_SIDE);
      default: base = AW'(2 * MAX_SIDE);
    endcase
    return base + AW'(x);
  endfunction

  // incoming sample position
  logic          acc_in;
  logic [SW-1:0] x_in, z_in;
  logic [1:0]    m_in;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign acc_in        = s_axis_tvalid && s_axis_tready;
  assign x_in = (col_q >= side) ? '0 : col_q;
  assign z_in = (row_q >= side) ? '0 : row_q;
  assign m_in = (row_q >= side) ? 2'd0 : zm_q;

  logic [2:0] pend_in;
  assign pend_in[0] = (z_in != '0);
  assign pend_in[1] = (z_in == side - SW'(1)) && (x_in != '0);
  assign pend_in[2] = (z_in == side - SW'(1)) && (x_in == side - SW'(1));

  // neighbour addresses of the normal in progress
  logic [SW-1:0] xl, xr;
  logic [1:0]    zdm, zum;
  logic [AW-1:0] raddr;
  logic          mem_re, mem_we;
  logic [HW-1:0] rdata;
  assign xl  = (px_q != '0) ? px_q - SW'(1) : '0;
  assign xr  = (px_q + SW'(1) < side) ? px_q + SW'(1) : side - SW'(1);
  assign zdm = (pz_q != '0) ? dec3(pm_q) : pm_q;
  assign zum = (pz_q + SW'(1) < side) ? inc3(pm_q) : pm_q;
  always_comb begin
    unique case (rcnt_q[1:0])
      2'd0:    raddr = slot_addr(pm_q, xl);
      2'd1:    raddr = slot_addr(pm_q, xr);
      2'd2:    raddr = slot_addr(zdm, px_q);
      default: raddr = slot_addr(zum, px_q);
    endcase
  end
  assign mem_re = (state_q == ST_READ) && (rcnt_q < 3'd4);
  assign mem_we = acc_in;

  hng_ram #(.DEPTH(DEPTH), .AW(AW), .WW(HW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (slot_addr(m_in, x_in)),
    .wdata_i (s_axis_tdata),
    .re_i    (mem_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // central differences and the shared squarer
  logic signed [DW-1:0]    dx, dz, mop;
  logic signed [2*DW-1:0]  sqr;
  assign dx = $signed({1'b0, nbr_q[0]}) - $signed({1'b0, nbr_q[1]});
  assign dz = $signed({1'b0, nbr_q[2]}) - $signed({1'b0, nbr_q[3]});
  always_comb begin
    unique case (mcnt_q)
      3'd0:    mop = dx;
      3'd1:    mop = $signed({1'b0, cell_q});
      default: mop = dz;
    endcase
  end
  assign sqr = mop * mop;

  // normaliser
  norm_req_t nreq;
  norm_res_t nres;
  logic      nstart, ndone;
  assign nreq.sq = acc_q;
  assign nreq.dx = dx;
  assign nreq.dy = cell_q;
  assign nreq.dz = dz;
  assign nstart  = (state_q == ST_MUL) && (mcnt_q == 3'd4);

  hng_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (nstart),
    .req_i   (nreq),
    .done_o  (ndone),
    .res_o   (nres)
  );

  logic          out_load;
  logic [2:0]    pend_pick;
  assign out_load = (state_q == ST_OUT) && (!tvalid_q || m_axis_tready);
  assign pend_pick = pend_q & ~(pend_q - 3'd1); // lowest pending normal

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (acc_in && pend_in != 3'b000) state_d = ST_PICK;
      ST_PICK: state_d = ST_READ;
      ST_READ: if (rcnt_q == 3'd4) state_d = ST_MUL;
      ST_MUL:  if (mcnt_q == 3'd4) state_d = ST_NORM;
      ST_NORM: if (ndone) state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = (pend_q == 3'b000) ? ST_IDLE : ST_PICK;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration, counters and statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= GSW'(1024);
      cell_q <= CDW'(256);
      col_q  <= '0;
      row_q  <= '0;
      zm_q   <= '0;
      min_q  <= '1;
      max_q  <= '0;
      pend_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_GRID_SIDE: begin
            grid_q <= cfg_data_i[GSW-1:0];
            col_q  <= '0;
            row_q  <= '0;
            zm_q   <= '0;
            min_q  <= '1;
            max_q  <= '0;
          end
          REG_CELL_DOUBLE: cell_q <= cfg_data_i;
          default: ;
        endcase
      end else if (acc_in) begin
        // new map: statistics restart on the first sample
        if (x_in == '0 && z_in == '0) begin
          min_q <= s_axis_tdata;
          max_q <= s_axis_tdata;
        end else begin
          if (s_axis_tdata < min_q) min_q <= s_axis_tdata;
          if (s_axis_tdata > max_q) max_q <= s_axis_tdata;
        end
        if (x_in + SW'(1) >= side) begin
          col_q <= '0;
          if (z_in + SW'(1) >= side) begin
            row_q <= '0;
            zm_q  <= '0;
          end else begin
            row_q <= z_in + SW'(1);
            zm_q  <= inc3(m_in);
          end
        end else begin
          col_q <= x_in + SW'(1);
          row_q <= z_in;
          zm_q  <= m_in;
        end
        pend_q <= pend_in;
      end else if (state_q == ST_PICK) begin
        pend_q <= pend_q & ~pend_pick;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      cx_q <= x_in;
      cz_q <= z_in;
      cm_q <= m_in;
    end
    unique case (state_q)
      ST_PICK: begin
        rcnt_q <= '0;
        last_q <= ((pend_q & ~pend_pick) == 3'b000);
        priority if (pend_pick[0]) begin
          px_q <= cx_q;
          pz_q <= cz_q - SW'(1);
          pm_q <= dec3(cm_q);
        end else if (pend_pick[1]) begin
          px_q <= cx_q - SW'(1);
          pz_q <= cz_q;
          pm_q <= cm_q;
        end else begin
          px_q <= cx_q;
          pz_q <= cz_q;
          pm_q <= cm_q;
        end
      end
      ST_READ: begin
        if (rcnt_q != 3'd0) nbr_q[rcnt_q[1:0] - 2'd1] <= rdata;
        rcnt_q <= rcnt_q + 3'd1;
        mcnt_q <= '0;
      end
      ST_MUL: begin
        prod_q <= PRW'(sqr);
        // sum held on the start cycle of the normaliser
        unique case (mcnt_q)
          3'd0:       acc_q <= '0;
          3'd1:       acc_q <= SQW'(prod_q);
          3'd2, 3'd3: acc_q <= acc_q + SQW'(prod_q);
          default: ;
        endcase
        mcnt_q <= mcnt_q + 3'd1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q <= 1'b0;
    end else if (out_load) begin
      tvalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      tdata_q <= {4'b0,
                  (px_q == side - SW'(1)) && (pz_q == side - SW'(1)),
                  max_q, min_q, nres.nz, nres.ny, nres.nx,
                  POSW'(pz_q), POSW'(px_q)};
      tlast_q <= last_q;
    end
  end

  assign m_axis_tvalid = tvalid_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tlast  = tlast_q;

`ifndef SYNTHESIS
  a_write_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == ST_IDLE) else $error("row store written outside idle");
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q < side) else $error("column counter beyond side");
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> pend_q == 3'b000) else $error("pending normals in idle");
  a_norm_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nstart |=> state_q == ST_NORM) else $error("normaliser started out of sequence");
`endif

endmodule
